/* rtl/sdss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdss_pkg
// Constants and byte-class helpers for the SQL dump statement splitter.
// ----------------------------------------------------------------------------
package sdss_pkg;

  localparam int MAX_TAG   = 16;
  localparam int TAG_LEN_W = $clog2(MAX_TAG + 2);
  localparam int TAG_IDX_W = (MAX_TAG > 1) ? $clog2(MAX_TAG) : 1;

  localparam logic [TAG_LEN_W-1:0] TAG_MAX_LEN  = TAG_LEN_W'(MAX_TAG);
  localparam logic [TAG_LEN_W-1:0] TAG_TOO_LONG = TAG_LEN_W'(MAX_TAG + 1);

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [3:0] COPY_LEN   = 4'd4;
  localparam logic [3:0] COPY_SP_LEN = 4'd5;
  localparam logic [3:0] INSERT_LEN = 4'd11;
  localparam logic [3:0] STDIN_LEN  = 4'd10;

  localparam logic [2:0] PFX_COPY    = 3'b001;
  localparam logic [2:0] PFX_COPY_SP = 3'b010;
  localparam logic [2:0] PFX_INSERT  = 3'b100;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_tag_byte(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] copy_char(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h63;
      4'd1:    r = 8'h6F;
      4'd2:    r = 8'h70;
      4'd3:    r = 8'h79;
      default: r = 8'h20;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] insert_char(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h69;
      4'd1:    r = 8'h6E;
      4'd2:    r = 8'h73;
      4'd3:    r = 8'h65;
      4'd4:    r = 8'h72;
      4'd5:    r = 8'h74;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h69;
      4'd8:    r = 8'h6E;
      4'd9:    r = 8'h74;
      default: r = 8'h6F;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] stdin_char(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h66;
      4'd1:    r = 8'h72;
      4'd2:    r = 8'h6F;
      4'd3:    r = 8'h6D;
      4'd4:    r = 8'h20;
      4'd5:    r = 8'h73;
      4'd6:    r = 8'h74;
      4'd7:    r = 8'h64;
      4'd8:    r = 8'h69;
      default: r = 8'h6E;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/sql_dump_statement_splitter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sql_dump_statement_splitter_top
// Splits a SQL dump byte stream into statements and flags each byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns one flagged beat per byte through a
// single output register; a new byte is taken in every cycle in which the
// output register is empty or being drained. All quote, dollar-tag,
// COPY-header and COPY-data tracking for a byte is done in the same cycle it
// is accepted. in_stall follows out_stall when the output register holds a
// beat. Asserting last_byte ends the dump and returns all tracking state to
// its reset value for the next dump.
module sql_dump_statement_splitter_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            keep,
  output logic            statement_end,
  output logic            copy_data,
  output logic            data_statement,
  output logic            tail_dropped,
  output logic            tag_overflow
);
  import sdss_pkg::*;

  typedef enum logic [1:0] {
    QM_OUTSIDE, QM_SINGLE, QM_DOLLAR, QM_COPY
  } quote_mode_t;

  typedef enum logic [1:0] {
    SP_NONE, SP_ESCAPE, SP_QUOTE, SP_UNUSED
  } single_pending_t;

  typedef enum logic [2:0] {
    CL_START, CL_BSLASH, CL_BSDOT, CL_BSDOTCR, CL_OTHER
  } copy_line_t;

  quote_mode_t          quote_mode, quote_mode_next;
  single_pending_t      single_pending, single_pending_next;
  copy_line_t           copy_line_state, copy_line_state_next;
  logic [TAG_LEN_W-1:0] tag_length, tag_length_next;
  logic [TAG_LEN_W-1:0] tag_progress, tag_progress_next;
  logic                 opening_candidate, opening_candidate_next;
  logic                 statement_started, statement_started_next;
  logic [3:0]           prefix_count, prefix_count_next;
  logic [2:0]           prefix_flags, prefix_flags_next;
  logic                 header_semicolon_seen, header_semicolon_seen_next;
  logic [3:0]           stdin_progress, stdin_progress_next;
  logic [7:0]           tag_store [MAX_TAG];

  logic                 tag_we;
  logic [TAG_IDX_W-1:0] tag_wa;
  logic                 in_fire;

  logic r_keep, r_end, r_copy, r_data, r_tail, r_ovf;

  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    logic [7:0]           c;
    logic [7:0]           lc;
    logic [7:0]           want;
    logic [TAG_LEN_W-1:0] rd_idx;
    logic [TAG_LEN_W:0]   prog_inc;
    logic [TAG_LEN_W:0]   close_len;
    logic                 do_outside;
    logic                 do_track;
    logic                 do_finish;

    c      = data_byte;
    lc     = to_lower(data_byte);
    want   = CH_DOLLAR;
    rd_idx = tag_progress - TAG_LEN_W'(1);
    prog_inc  = {1'b0, tag_progress} + (TAG_LEN_W+1)'(1);
    close_len = {1'b0, tag_length} + (TAG_LEN_W+1)'(2);
    do_outside = 1'b0;
    do_track   = 1'b0;
    do_finish  = 1'b0;

    quote_mode_next            = quote_mode;
    single_pending_next        = single_pending;
    copy_line_state_next       = copy_line_state;
    tag_length_next            = tag_length;
    tag_progress_next          = tag_progress;
    opening_candidate_next     = opening_candidate;
    statement_started_next     = statement_started;
    prefix_count_next          = prefix_count;
    prefix_flags_next          = prefix_flags;
    header_semicolon_seen_next = header_semicolon_seen;
    stdin_progress_next        = stdin_progress;
    tag_we = 1'b0;
    tag_wa = tag_length[TAG_IDX_W-1:0];

    r_keep = 1'b0;
    r_end  = 1'b0;
    r_copy = 1'b0;
    r_data = 1'b0;
    r_tail = 1'b0;
    r_ovf  = 1'b0;

    if (quote_mode == QM_COPY) begin
      r_keep = 1'b1;
      r_copy = 1'b1;
      if (c == CH_LF) begin
        if (copy_line_state == CL_BSDOT || copy_line_state == CL_BSDOTCR) begin
          do_finish = 1'b1;
        end else begin
          copy_line_state_next = CL_START;
        end
      end else if (copy_line_state == CL_START && c == CH_BSLASH) begin
        copy_line_state_next = CL_BSLASH;
      end else if (copy_line_state == CL_BSLASH && c == CH_DOT) begin
        copy_line_state_next = CL_BSDOT;
      end else if (copy_line_state == CL_BSDOT && c == CH_CR) begin
        copy_line_state_next = CL_BSDOTCR;
      end else begin
        copy_line_state_next = CL_OTHER;
      end
    end else if (quote_mode == QM_SINGLE) begin
      if (single_pending == SP_QUOTE && c != CH_QUOTE) begin
        single_pending_next = SP_NONE;
        quote_mode_next     = QM_OUTSIDE;
        do_outside          = 1'b1;
      end else begin
        do_track = 1'b1;
        if (single_pending != SP_NONE) begin
          single_pending_next = SP_NONE;
        end else if (c == CH_BSLASH) begin
          single_pending_next = SP_ESCAPE;
        end else if (c == CH_QUOTE) begin
          single_pending_next = SP_QUOTE;
        end
      end
    end else if (quote_mode == QM_DOLLAR) begin
      do_track = 1'b1;
      if (tag_progress != '0 && tag_progress <= tag_length) begin
        want = tag_store[rd_idx[TAG_IDX_W-1:0]];
      end
      if (c == want) begin
        if (prog_inc >= close_len) begin
          quote_mode_next   = QM_OUTSIDE;
          tag_progress_next = '0;
        end else begin
          tag_progress_next = prog_inc[TAG_LEN_W-1:0];
        end
      end else begin
        tag_progress_next = (c == CH_DOLLAR) ? TAG_LEN_W'(1) : '0;
      end
    end else if (opening_candidate) begin
      if (is_tag_byte(c)) begin
        do_track = 1'b1;
        if (tag_length < TAG_MAX_LEN) begin
          tag_we          = 1'b1;
          tag_length_next = tag_length + TAG_LEN_W'(1);
        end else begin
          tag_length_next = TAG_TOO_LONG;
        end
      end else if (c == CH_DOLLAR) begin
        do_track               = 1'b1;
        opening_candidate_next = 1'b0;
        if (tag_length > TAG_MAX_LEN) begin
          r_ovf = 1'b1;
        end else begin
          quote_mode_next   = QM_DOLLAR;
          tag_progress_next = '0;
        end
      end else begin
        opening_candidate_next = 1'b0;
        do_outside             = 1'b1;
      end
    end else begin
      do_outside = 1'b1;
    end

    if (do_outside) begin
      if (!statement_started && is_ws(c)) begin
        do_outside = 1'b0;
      end else begin
        statement_started_next = 1'b1;
        do_track               = 1'b1;
      end
    end

    if (do_track) begin
      r_keep = 1'b1;
      if (prefix_count < INSERT_LEN) begin
        if (prefix_count < COPY_LEN && lc != copy_char(prefix_count)) begin
          prefix_flags_next = prefix_flags_next & ~PFX_COPY;
        end
        if (prefix_count < COPY_SP_LEN && lc != copy_char(prefix_count)) begin
          prefix_flags_next = prefix_flags_next & ~PFX_COPY_SP;
        end
        if (lc != insert_char(prefix_count)) begin
          prefix_flags_next = prefix_flags_next & ~PFX_INSERT;
        end
        prefix_count_next = prefix_count + 4'd1;
      end
      if (!header_semicolon_seen) begin
        if (c == CH_SEMI) begin
          header_semicolon_seen_next = 1'b1;
        end else if (stdin_progress < STDIN_LEN) begin
          if (lc == stdin_char(stdin_progress)) begin
            stdin_progress_next = stdin_progress + 4'd1;
          end else begin
            stdin_progress_next = (lc == CH_F) ? 4'd1 : 4'd0;
          end
        end
      end
    end

    if (do_outside) begin
      if (c == CH_QUOTE) begin
        quote_mode_next     = QM_SINGLE;
        single_pending_next = SP_NONE;
      end else if (c == CH_DOLLAR) begin
        opening_candidate_next = 1'b1;
        tag_length_next        = '0;
      end else if (c == CH_SEMI) begin
        if ((prefix_flags_next & PFX_COPY) != '0 && prefix_count_next >= COPY_LEN &&
            stdin_progress_next == STDIN_LEN) begin
          quote_mode_next      = QM_COPY;
          copy_line_state_next = CL_START;
        end else begin
          do_finish = 1'b1;
        end
      end
    end

    if (!do_finish && last_byte && quote_mode_next == QM_COPY) begin
      do_finish = 1'b1;
    end
    if (!do_finish && last_byte && statement_started_next) begin
      r_tail = 1'b1;
    end

    if (do_finish) begin
      r_end  = 1'b1;
      r_data = (((prefix_flags_next & PFX_COPY_SP) != '0) &&
                (prefix_count_next >= COPY_SP_LEN)) ||
               (((prefix_flags_next & PFX_INSERT) != '0) &&
                (prefix_count_next >= INSERT_LEN));
      quote_mode_next            = QM_OUTSIDE;
      statement_started_next     = 1'b0;
      prefix_count_next          = '0;
      prefix_flags_next          = '1;
      header_semicolon_seen_next = 1'b0;
      stdin_progress_next        = '0;
      opening_candidate_next     = 1'b0;
    end

    if (last_byte) begin
      quote_mode_next            = QM_OUTSIDE;
      single_pending_next        = SP_NONE;
      tag_length_next            = '0;
      tag_progress_next          = '0;
      copy_line_state_next       = CL_START;
      statement_started_next     = 1'b0;
      prefix_count_next          = '0;
      prefix_flags_next          = '1;
      header_semicolon_seen_next = 1'b0;
      stdin_progress_next        = '0;
      opening_candidate_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && tag_we) begin
      tag_store[tag_wa] <= data_byte;
    end
    if (in_fire) begin
      out_byte       <= data_byte;
      keep           <= r_keep;
      statement_end  <= r_end;
      copy_data      <= r_copy;
      data_statement <= r_data;
      tail_dropped   <= r_tail;
      tag_overflow   <= r_ovf;
    end
    if (rst) begin
      out_valid             <= 1'b0;
      quote_mode            <= QM_OUTSIDE;
      single_pending        <= SP_NONE;
      copy_line_state       <= CL_START;
      tag_length            <= '0;
      tag_progress          <= '0;
      opening_candidate     <= 1'b0;
      statement_started     <= 1'b0;
      prefix_count          <= '0;
      prefix_flags          <= '1;
      header_semicolon_seen <= 1'b0;
      stdin_progress        <= '0;
    end else begin
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        quote_mode            <= quote_mode_next;
        single_pending        <= single_pending_next;
        copy_line_state       <= copy_line_state_next;
        tag_length            <= tag_length_next;
        tag_progress          <= tag_progress_next;
        opening_candidate     <= opening_candidate_next;
        statement_started     <= statement_started_next;
        prefix_count          <= prefix_count_next;
        prefix_flags          <= prefix_flags_next;
        header_semicolon_seen <= header_semicolon_seen_next;
        stdin_progress        <= stdin_progress_next;
      end
    end
  end

endmodule
`default_nettype wire

/* dv/sql_dump_statement_splitter_top_tb.sv */
// ----------------------------------------------------------------------------
// sql_dump_statement_splitter_top_tb
// Checks the per-byte statement flags of the SQL dump splitter. Whole dumps
// (plain, insert and COPY-from-stdin statements, quoted strings, dollar
// blocks, broken tags and noise) are fed in; a scoreboard predicts the flags
// of every accepted byte and compares them with each output beat in order.
// ----------------------------------------------------------------------------
module sql_dump_statement_splitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdss_pkg::*;

  typedef enum logic [1:0] {QM_OUT, QM_SINGLE, QM_DOLLAR, QM_COPY} quote_t;
  typedef enum logic [1:0] {SP_NONE, SP_ESCAPE, SP_QUOTE} pend_t;
  typedef enum logic [2:0] {LN_START, LN_BSLASH, LN_DOT, LN_DOT_CR, LN_OTHER} line_t;

  typedef struct packed {
    logic [7:0] val;
    logic       keep;
    logic       ends;
    logic       copy;
    logic       data;
    logic       tail;
    logic       ovf;
  } flag_beat_t;

  class stmt_flag_board;
    flag_beat_t flags_due[$];
    int         errors;
    quote_t     qmode;
    pend_t      pend;
    line_t      cline;
    logic [7:0] tag_chars[MAX_TAG];
    int unsigned tlen, tprog, pfx_cnt, stdin_cnt;
    bit         cand, started, hdr_semi;
    logic [2:0] pfx;
    flag_beat_t cur;
    string      copy_word, insert_word, stdin_word;

    function new();
      copy_word   = "copy ";
      insert_word = "insert into";
      stdin_word  = "from stdin";
      errors      = 0;
      clear_all();
    endfunction

    function int pending();
      return flags_due.size();
    endfunction

    function void new_statement();
      started   = 1'b0;
      pfx_cnt   = 0;
      pfx       = PFX_COPY | PFX_COPY_SP | PFX_INSERT;
      hdr_semi  = 1'b0;
      stdin_cnt = 0;
      cand      = 1'b0;
    endfunction

    function void clear_all();
      qmode = QM_OUT;
      pend  = SP_NONE;
      cline = LN_START;
      tlen  = 0;
      tprog = 0;
      foreach (tag_chars[i]) tag_chars[i] = 8'h00;
      new_statement();
    endfunction

    function logic is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function void track(logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      cur.keep = 1'b1;
      if (pfx_cnt < INSERT_LEN) begin
        if (pfx_cnt < COPY_LEN && lc != copy_word[pfx_cnt]) pfx &= ~PFX_COPY;
        if (pfx_cnt < COPY_SP_LEN && lc != copy_word[pfx_cnt]) pfx &= ~PFX_COPY_SP;
        if (lc != insert_word[pfx_cnt]) pfx &= ~PFX_INSERT;
        pfx_cnt++;
      end
      if (!hdr_semi) begin
        if (c == CH_SEMI) hdr_semi = 1'b1;
        else if (stdin_cnt < STDIN_LEN) begin
          if (lc == stdin_word[stdin_cnt]) stdin_cnt++;
          else stdin_cnt = (lc == CH_F) ? 1 : 0;
        end
      end
    endfunction

    function void close_statement();
      cur.ends = 1'b1;
      cur.data = ((pfx & PFX_COPY_SP) != 0 && pfx_cnt >= COPY_SP_LEN) ||
                 ((pfx & PFX_INSERT) != 0 && pfx_cnt >= INSERT_LEN);
      qmode = QM_OUT;
      new_statement();
    endfunction

    function void outside(logic [7:0] c);
      if (!started && is_blank(c)) begin
        cur.keep = 1'b0;
        return;
      end
      started = 1'b1;
      track(c);
      if (c == CH_QUOTE) begin
        qmode = QM_SINGLE;
        pend  = SP_NONE;
      end else if (c == CH_DOLLAR) begin
        cand = 1'b1;
        tlen = 0;
      end else if (c == CH_SEMI) begin
        if ((pfx & PFX_COPY) != 0 && pfx_cnt >= COPY_LEN && stdin_cnt == STDIN_LEN) begin
          qmode = QM_COPY;
          cline = LN_START;
        end else begin
          close_statement();
        end
      end
    endfunction

    function void note_byte(logic [7:0] c, logic l);
      logic [7:0] want;
      cur = '0;
      case (qmode)
        QM_COPY: begin
          cur.keep = 1'b1;
          cur.copy = 1'b1;
          if (c == CH_LF) begin
            if (cline == LN_DOT || cline == LN_DOT_CR) close_statement();
            else cline = LN_START;
          end else if (cline == LN_START && c == CH_BSLASH) cline = LN_BSLASH;
          else if (cline == LN_BSLASH && c == CH_DOT) cline = LN_DOT;
          else if (cline == LN_DOT && c == CH_CR) cline = LN_DOT_CR;
          else cline = LN_OTHER;
        end
        QM_SINGLE: begin
          if (pend == SP_QUOTE && c != CH_QUOTE) begin
            pend  = SP_NONE;
            qmode = QM_OUT;
            outside(c);
          end else begin
            track(c);
            if (pend != SP_NONE) pend = SP_NONE;
            else if (c == CH_BSLASH) pend = SP_ESCAPE;
            else if (c == CH_QUOTE) pend = SP_QUOTE;
          end
        end
        QM_DOLLAR: begin
          track(c);
          if (tprog == 0 || tprog > tlen) want = CH_DOLLAR;
          else want = tag_chars[tprog-1];
          if (c == want) begin
            tprog++;
            if (tprog >= tlen + 2) begin
              qmode = QM_OUT;
              tprog = 0;
            end
          end else begin
            tprog = (c == CH_DOLLAR) ? 1 : 0;
          end
        end
        default: begin
          if (!cand) outside(c);
          else if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                   (c >= "A" && c <= "Z") || c == "_") begin
            track(c);
            if (tlen < MAX_TAG) begin
              tag_chars[tlen] = c;
              tlen++;
            end else begin
              tlen = MAX_TAG + 1;
            end
          end else if (c == CH_DOLLAR) begin
            track(c);
            cand = 1'b0;
            if (tlen > MAX_TAG) cur.ovf = 1'b1;
            else begin
              qmode = QM_DOLLAR;
              tprog = 0;
            end
          end else begin
            cand = 1'b0;
            outside(c);
          end
        end
      endcase
      if (l) begin
        if (!cur.ends) begin
          if (qmode == QM_COPY) close_statement();
          else if (started) cur.tail = 1'b1;
        end
        clear_all();
      end
      cur.val = c;
      flags_due = {flags_due, cur};
    endfunction

    function void cmp(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_beat(flag_beat_t got);
      flag_beat_t want_beat;
      if (flags_due.size() == 0) begin
        errors++;
        $display("%0t: beat with no byte pending, expected none actual %h", $time, got.val);
        return;
      end
      want_beat = flags_due.pop_front();
      cmp("out_byte", want_beat.val, got.val);
      cmp("keep", want_beat.keep, got.keep);
      cmp("statement_end", want_beat.ends, got.ends);
      cmp("copy_data", want_beat.copy, got.copy);
      cmp("data_statement", want_beat.data, got.data);
      cmp("tail_dropped", want_beat.tail, got.tail);
      cmp("tag_overflow", want_beat.ovf, got.ovf);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       keep, statement_end, copy_data, data_statement, tail_dropped, tag_overflow;

  stmt_flag_board board;
  flag_beat_t     seen_beat;
  logic [7:0]     dump_text[$];
  bit             tx_idle;
  logic           rx_idle_on = 1'b0;
  int             holds_asked = 0;
  int             holds_done = 0;
  int             rx_hold = 0;
  int             bytes_sent = 0;

  localparam int LONG_HOLD = 80;

  sql_dump_statement_splitter_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .keep          (keep),
    .statement_end (statement_end),
    .copy_data     (copy_data),
    .data_statement(data_statement),
    .tail_dropped  (tail_dropped),
    .tag_overflow  (tag_overflow)
  );

  assign seen_beat = {out_byte, keep, statement_end, copy_data, data_statement,
                      tail_dropped, tag_overflow};

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_beat(seen_beat);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else if (holds_done < holds_asked) begin
      holds_done <= holds_done + 1;
      rx_hold    <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold   <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void add_char(logic [7:0] c);
    dump_text = {dump_text, c};
  endfunction

  function automatic void put_text(string s, bit vary_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (vary_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
          $urandom_range(0, 2) == 0)
        c = c ^ 8'h20;
      add_char(c);
    end
  endfunction

  function automatic void put_blanks(int n);
    for (int i = 0; i < n; i++)
      add_char(($urandom_range(0, 2) == 0) ? 8'h20 : 8'(8 + $urandom_range(1, 5)));
  endfunction

  function automatic logic [7:0] rand_tag_char();
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic void put_tag(logic [7:0] tag[$]);
    add_char(CH_DOLLAR);
    foreach (tag[i]) add_char(tag[i]);
    add_char(CH_DOLLAR);
  endfunction

  function automatic void put_quoted();
    int n;
    n = $urandom_range(0, 8);
    add_char(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 6))
        0: add_char(CH_SEMI);
        1: begin
          add_char(CH_BSLASH);
          add_char(8'($urandom_range(32, 126)));
        end
        2: put_text("''", 0);
        3: add_char(CH_DOLLAR);
        4: put_text("\\'", 0);
        default: add_char(8'($urandom_range(32, 126)));
      endcase
    end
    add_char(CH_QUOTE);
  endfunction

  function automatic void put_dollar_block();
    logic [7:0] tag[$];
    int tl, n, k;
    tl = ($urandom_range(0, 6) == 0) ? $urandom_range(MAX_TAG - 1, MAX_TAG + 2)
                                     : $urandom_range(0, 3);
    for (int i = 0; i < tl; i++) tag = {tag, rand_tag_char()};
    put_tag(tag);
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: add_char(CH_SEMI);
        1: add_char(CH_QUOTE);
        2: begin
          k = $urandom_range(0, tl);
          add_char(CH_DOLLAR);
          for (int j = 0; j < k; j++) add_char(tag[j]);
        end
        3: add_char(CH_DOLLAR);
        default: add_char(8'($urandom_range(32, 126)));
      endcase
    end
    put_tag(tag);
  endfunction

  function automatic void put_copy_stmt(bit from_input, bit closed);
    int lines, n;
    put_text("copy ", 1);
    put_text("t_data", 0);
    if ($urandom_range(0, 1)) put_text(" (a, b)", 0);
    if ($urandom_range(0, 5) == 0) put_quoted();
    put_text(from_input ? " from stdin" : " to stdout", 1);
    add_char(CH_SEMI);
    if (!from_input) return;
    lines = $urandom_range(0, 3);
    for (int i = 0; i < lines; i++) begin
      n = $urandom_range(0, 8);
      for (int j = 0; j < n; j++) begin
        case ($urandom_range(0, 6))
          0: add_char(CH_BSLASH);
          1: add_char(CH_DOT);
          2: add_char(CH_CR);
          3: add_char(8'h09);
          4: add_char(8'($urandom_range(0, 255)));
          default: add_char(8'($urandom_range(32, 126)));
        endcase
      end
      add_char(CH_LF);
    end
    if (closed) begin
      put_text("\\.", 0);
      if ($urandom_range(0, 1)) add_char(CH_CR);
      add_char(CH_LF);
    end
  endfunction

  function automatic void put_misc_stmt(bit closed);
    int n, k;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          case ($urandom_range(0, 7))
            0: put_text("select 1", 1);
            1: put_text("create table t_1 (a int)", 1);
            2: put_text("copy", 1);
            3: put_text("insert", 1);
            4: put_text("from stdin", 1);
            5: put_text("fromfrom stdi", 0);
            6: put_text("set x = 'y'", 0);
            default: put_text("update t set a = 2", 1);
          endcase
        end
        2: put_blanks($urandom_range(1, 2));
        3: put_quoted();
        4: put_dollar_block();
        5: begin
          add_char(CH_DOLLAR);
          k = $urandom_range(0, 3);
          for (int j = 0; j < k; j++) add_char(rand_tag_char());
          case ($urandom_range(0, 4))
            0: add_char(8'h20);
            1: add_char(CH_SEMI);
            2: add_char(CH_QUOTE);
            3: add_char(8'h28);
            default: add_char(CH_LF);
          endcase
        end
        default: begin
          k = $urandom_range(1, 3);
          for (int j = 0; j < k; j++) add_char(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if (closed) add_char(CH_SEMI);
  endfunction

  function automatic void build_dump();
    int n;
    dump_text.delete();
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) put_blanks($urandom_range(1, 3));
      case ($urandom_range(0, 9))
        0, 1, 2: put_copy_stmt(1'b1, 1'b1);
        3: put_copy_stmt(1'b0, 1'b1);
        4, 5: begin
          put_text("insert into", 1);
          put_text(" t values (", 0);
          if ($urandom_range(0, 2) == 0) put_dollar_block();
          else put_quoted();
          put_text(", 42);", 0);
        end
        default: put_misc_stmt(1'b1);
      endcase
    end
    case ($urandom_range(0, 4))
      1: put_blanks($urandom_range(1, 3));
      2: put_misc_stmt(1'b0);
      3: put_copy_stmt(1'b1, 1'b0);
      default: ;
    endcase
    if (dump_text.size() == 0) add_char(CH_SEMI);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic l);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= c;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(c, l);
    bytes_sent++;
  endtask

  task automatic send_dump();
    foreach (dump_text[i]) send_byte(dump_text[i], i == dump_text.size() - 1);
  endtask

  initial begin
    int dumps;
    int drain_cycles;
    board = new();
    dumps = 0;
    drain_cycles = 0;
    tx_idle = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    rx_idle_on <= 1'b1;

    dump_text = '{8'h00, 8'hFF, CH_SEMI};
    send_dump();
    dump_text.delete();
    put_text(" \tx", 0);
    send_dump();
    dump_text.delete();
    put_text("\n ", 0);
    send_dump();
    dump_text.delete();
    put_text("'a'';\\'';", 0);
    send_dump();
    dump_text.delete();
    put_text("$q$;$q$;", 0);
    send_dump();
    dump_text.delete();
    put_text("$ab c;", 0);
    send_dump();

    while (bytes_sent < 1600) begin
      tx_idle = (bytes_sent < 500) || (bytes_sent >= 800 && bytes_sent < 1300);
      rx_idle_on <= tx_idle;
      if (dumps == 1 || dumps == 7) holds_asked <= holds_asked + 1;
      if (dumps == 4 || dumps == 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
      end
      build_dump();
      send_dump();
      dumps++;
    end
    in_valid <= 1'b0;

    while (board.pending() != 0 && drain_cycles < 1000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: bytes left without a beat, expected 0 actual %0d", $time, board.pending());
    end
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/sdss_pkg.sv
rtl/sql_dump_statement_splitter_top.sv
dv/sql_dump_statement_splitter_top_tb.sv
